/* rtl/binary_to_decimal_ascii_defines.svh */
// Assertion macros shared by the binary_to_decimal_ascii RTL files.
`ifndef BINARY_TO_DECIMAL_ASCII_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_DEFINES_SVH

`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define B2DA_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("b2da assertion failed");
// Condition must never be true outside reset.
`define B2DA_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("b2da forbidden condition seen");
`else
`define B2DA_ASSERT(label, clk, rst_n, prop)
`define B2DA_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

/* rtl/b2da_pkg.sv */
// Shared constants and types for the binary to decimal ASCII converter.
`default_nettype none

package b2da_pkg;

	localparam int VALUE_W       = 32;
	localparam int DIGIT_W       = 4;
	localparam int NUM_DIGITS    = 10;
	localparam int BCD_W         = NUM_DIGITS * DIGIT_W;
	localparam int CHAR_W        = 6;
	localparam int CNT_W         = 4;
	localparam int BITS_PER_STEP = 4;
	localparam int STEPS         = VALUE_W / BITS_PER_STEP;
	localparam int STEP_W        = 3;

	localparam logic [CHAR_W-1:0] ZERO_CHAR = 6'd48;

	// One converted value waiting to be printed.
	typedef struct packed {
		logic [BCD_W-1:0] bcd;
		logic [CNT_W-1:0] ndig;
	} b2da_entry_t;

endpackage

`default_nettype wire

/* rtl/binary_to_decimal_ascii.sv */
// Binary to decimal ASCII converter: 32-bit unsigned value in, digit characters out.
//
// Input channel (value_valid/value_ready) takes one 32-bit unsigned value per transfer.
// Output channel (digit_valid/digit_ready) returns that value's decimal digits as
// ASCII codes, most significant first, no leading zeros; zero prints as one '0'.
// last_digit is set on the final digit of each number.
// The front end converts to BCD with a shift-and-add-3 unit that takes four input
// bits per cycle: it loads a value, runs eight shift steps, then pushes the result to
// the queue, and takes no new value until that push is done. The back end loads each
// value from the queue and sends its digits one per cycle while digit_ready is high;
// each digit character is registered before it reaches the output.
// A queue of QUEUE_DEPTH converted values sits between the two ends, so a stalled
// receiver holds the digit stream while the front keeps converting until the queue
// fills; then value_ready stays low. A stalled digit holds its payload.
// Reset empties the queue and clears all valid flags; no item survives reset.
`default_nettype none

module binary_to_decimal_ascii #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [b2da_pkg::VALUE_W-1:0]  value,
	input  wire logic                          value_valid,
	output logic                               value_ready,
	output logic [b2da_pkg::CHAR_W-1:0]        digit_char,
	output logic                               last_digit,
	output logic                               digit_valid,
	input  wire logic                          digit_ready
);
	import b2da_pkg::*;

	logic        push;
	logic        pop;
	logic        full;
	logic        empty;
	b2da_entry_t push_entry;
	b2da_entry_t pop_entry;

	b2da_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.value       (value),
		.value_valid (value_valid),
		.value_ready (value_ready),
		.push        (push),
		.push_entry  (push_entry),
		.full        (full)
	);

	b2da_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.empty      (empty)
	);

	b2da_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop         (pop),
		.pop_entry   (pop_entry),
		.empty       (empty),
		.digit_valid (digit_valid),
		.digit_ready (digit_ready),
		.digit_char  (digit_char),
		.last_digit  (last_digit)
	);

endmodule

`default_nettype wire

/* rtl/b2da_front.sv */
// Front end: accepts a value and converts it to packed BCD, four bits per cycle.
`default_nettype none

module b2da_front (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic [b2da_pkg::VALUE_W-1:0]   value,
	input  wire logic                           value_valid,
	output logic                                value_ready,
	output logic                                push,
	output b2da_pkg::b2da_entry_t               push_entry,
	input  wire logic                           full
);
	import b2da_pkg::*;

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_CONV = 3'b010,
		F_PUSH = 3'b100
	} front_state_t;

	front_state_t       state_q;
	logic [STEP_W-1:0]  step_q;
	logic [VALUE_W-1:0] shift_q;
	logic [BCD_W-1:0]   bcd_q;
	logic [VALUE_W-1:0] shift_n;
	logic [BCD_W-1:0]   bcd_n;
	logic [CNT_W-1:0]   ndig;

	// Add 3 to every BCD digit of 5 or more before the next shift.
	function automatic logic [BCD_W-1:0] add3(input logic [BCD_W-1:0] b);
		logic [BCD_W-1:0] r;
		r = b;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (r[i*DIGIT_W +: DIGIT_W] >= 4'd5)
				r[i*DIGIT_W +: DIGIT_W] = r[i*DIGIT_W +: DIGIT_W] + 4'd3;
		end
		return r;
	endfunction

	always_comb begin
		bcd_n   = bcd_q;
		shift_n = shift_q;
		for (int j = 0; j < BITS_PER_STEP; j++) begin
			bcd_n   = add3(bcd_n);
			bcd_n   = {bcd_n[BCD_W-2:0], shift_n[VALUE_W-1]};
			shift_n = {shift_n[VALUE_W-2:0], 1'b0};
		end
	end

	// Digit count: position of the highest nonzero digit, at least one.
	always_comb begin
		ndig = CNT_W'(1);
		for (int i = 1; i < NUM_DIGITS; i++) begin
			if (bcd_q[i*DIGIT_W +: DIGIT_W] != '0)
				ndig = CNT_W'(i + 1);
		end
	end

	assign value_ready     = (state_q == F_IDLE);
	assign push            = (state_q == F_PUSH) && !full;
	assign push_entry.bcd  = bcd_q;
	assign push_entry.ndig = ndig;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (value_valid) begin
						state_q <= F_CONV;
						step_q  <= '0;
					end
				end
				F_CONV: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(STEPS - 1))
						state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (!full)
						state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (value_ready && value_valid) begin
			shift_q <= value;
			bcd_q   <= '0;
		end else if (state_q == F_CONV) begin
			shift_q <= shift_n;
			bcd_q   <= bcd_n;
		end
	end

endmodule

`default_nettype wire

/* rtl/b2da_queue.sv */
// Small queue of converted values between the front and back ends.
`default_nettype none
`include "binary_to_decimal_ascii_defines.svh"

module b2da_queue #(
	parameter int DEPTH = 2
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire b2da_pkg::b2da_entry_t push_entry,
	output logic                       full,
	input  wire logic                  pop,
	output b2da_pkg::b2da_entry_t      pop_entry,
	output logic                       empty
);
	import b2da_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	b2da_entry_t      mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign pop_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop)
				rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_entry;
	end

	`B2DA_ASSERT_NEVER(a_push_when_full, clk, arst_n, push && full)
	`B2DA_ASSERT_NEVER(a_pop_when_empty, clk, arst_n, pop && empty)
	`B2DA_ASSERT(a_count_bound, clk, arst_n, count_q <= CNT_W'(DEPTH))

endmodule

`default_nettype wire

/* rtl/b2da_back.sv */
// Back end: walks the digits of one queued value out, most significant first.
`default_nettype none
`include "binary_to_decimal_ascii_defines.svh"

module b2da_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	output logic                               pop,
	input  wire b2da_pkg::b2da_entry_t         pop_entry,
	input  wire logic                          empty,
	output logic                               digit_valid,
	input  wire logic                          digit_ready,
	output logic [b2da_pkg::CHAR_W-1:0]        digit_char,
	output logic                               last_digit
);
	import b2da_pkg::*;

	logic               busy_q;
	logic [CNT_W-1:0]   idx_q;
	logic [BCD_W-1:0]   bcd_q;
	logic               out_valid_q;
	logic [CHAR_W-1:0]  char_q;
	logic               last_q;
	logic               slot_free;
	logic [DIGIT_W-1:0] cur_digit;

	assign slot_free = !out_valid_q || digit_ready;
	assign pop       = !busy_q && !empty;
	assign cur_digit = bcd_q[idx_q*DIGIT_W +: DIGIT_W];

	assign digit_valid = out_valid_q;
	assign digit_char  = char_q;
	assign last_digit  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop)
				busy_q <= 1'b1;
			else if (busy_q && slot_free && idx_q == '0)
				busy_q <= 1'b0;
			if (slot_free)
				out_valid_q <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			bcd_q <= pop_entry.bcd;
			idx_q <= pop_entry.ndig - 1'b1;
		end else if (busy_q && slot_free) begin
			idx_q <= idx_q - 1'b1;
		end
		if (busy_q && slot_free) begin
			char_q <= ZERO_CHAR + CHAR_W'(cur_digit);
			last_q <= (idx_q == '0);
		end
	end

	`B2DA_ASSERT(a_char_range, clk, arst_n,
		digit_valid |-> (digit_char >= ZERO_CHAR && digit_char <= ZERO_CHAR + 6'd9))
	`B2DA_ASSERT(a_index_range, clk, arst_n, busy_q |-> idx_q < CNT_W'(NUM_DIGITS))
	`B2DA_ASSERT(a_last_ends_run, clk, arst_n,
		(busy_q && slot_free && idx_q == '0) |=> (!busy_q && out_valid_q && last_q))

endmodule

`default_nettype wire
